// ===== hdl/ddpi_pkg.sv =====
// shared widths, constants and the arctangent table for the pose integrator
`timescale 1ns / 1ps
`default_nettype none

package ddpi_pkg;

   localparam int LinSpeedW = 16;
   localparam int YawRateW  = 16;
   localparam int ElapsedW  = 20;
   localparam int PosW      = 32;
   localparam int QuatW     = 16;
   localparam int AngleW    = 32;

   localparam int CordicSteps   = 16;
   localparam int AngleTableLen = 24;
   localparam int CordicIters   = (CordicSteps > AngleTableLen) ? AngleTableLen : CordicSteps;
   localparam int IterW         = $clog2(AngleTableLen);
   localparam logic [IterW-1:0] IterLast = IterW'(CordicIters - 1);

   // cordic gain 0.60725293 in q30
   localparam logic signed [31:0] CordicGain = 32'sd652032874;
   // round(2^28 / (4 pi))
   localparam logic signed [25:0] RadToBam = 26'sd21361415;

   // atan(2^-i), 2^32 is a full turn
   function automatic logic [AngleW-1:0] atan_angle(input logic [IterW-1:0] idx);
      logic [AngleW-1:0] res;
      case (idx)
         5'd0:    res = 32'd536870912;
         5'd1:    res = 32'd316933406;
         5'd2:    res = 32'd167458907;
         5'd3:    res = 32'd85004756;
         5'd4:    res = 32'd42667331;
         5'd5:    res = 32'd21354465;
         5'd6:    res = 32'd10679838;
         5'd7:    res = 32'd5340245;
         5'd8:    res = 32'd2670163;
         5'd9:    res = 32'd1335087;
         5'd10:   res = 32'd667544;
         5'd11:   res = 32'd333772;
         5'd12:   res = 32'd166886;
         5'd13:   res = 32'd83443;
         5'd14:   res = 32'd41722;
         5'd15:   res = 32'd20861;
         5'd16:   res = 32'd10430;
         5'd17:   res = 32'd5215;
         5'd18:   res = 32'd2608;
         5'd19:   res = 32'd1304;
         5'd20:   res = 32'd652;
         5'd21:   res = 32'd326;
         5'd22:   res = 32'd163;
         5'd23:   res = 32'd81;
         default: res = 32'd0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ddpi_if.sv =====
// request and response channel interfaces of the pose integrator
`timescale 1ns / 1ps
`default_nettype none

interface ddpi_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ddpi_pkg::LinSpeedW-1:0]  lin_speed;
   logic signed [ddpi_pkg::YawRateW-1:0]   yaw_rate;
   logic        [ddpi_pkg::ElapsedW-1:0]   elapsed;

   modport source (output valid, output lin_speed, output yaw_rate, output elapsed,
                   input ready);
   modport sink (input valid, input lin_speed, input yaw_rate, input elapsed,
                 output ready);
endinterface

interface ddpi_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ddpi_pkg::PosW-1:0]   pos_x;
   logic signed [ddpi_pkg::PosW-1:0]   pos_y;
   logic signed [ddpi_pkg::QuatW-1:0]  quat_z;
   logic signed [ddpi_pkg::QuatW-1:0]  quat_w;

   modport source (output valid, output pos_x, output pos_y, output quat_z, output quat_w,
                   input ready);
   modport sink (input valid, input pos_x, input pos_y, input quat_z, input quat_w,
                 output ready);
endinterface

`default_nettype wire

// ===== hdl/diff_drive_pose_integrator.sv =====
// differential-drive pose integrator: euler odometry step and yaw quaternion
`timescale 1ns / 1ps
`default_nettype none

// Each request (speed, yaw rate, elapsed time) advances x and y along the old
// heading, then the heading, and returns the saturated position with the yaw
// quaternion z and w in Q1.14. One request is taken at a time: after an
// acceptance ready stays low until the result is copied into the response
// register, and that copy waits while the register still holds an untaken one.
// Each request takes two passes of the single CORDIC rotator (one iteration
// per cycle) and a ten-step sequence through the one 33x26 multiplier. A
// response waits in its own register, so the next request is accepted while it
// is pending. Pose resets to zero.
module diff_drive_pose_integrator (
   input  wire logic   clock,
   input  wire logic   reset,
   ddpi_req_if.sink    req_chan,
   ddpi_rsp_if.source  rsp_chan
);

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_ROT_A  = 15'b000000000000010,
      S_FIN_A  = 15'b000000000000100,
      S_MUL_VC = 15'b000000000001000,
      S_MUL_XD = 15'b000000000010000,
      S_RND_X  = 15'b000000000100000,
      S_ADD_X  = 15'b000000001000000,
      S_RND_Y  = 15'b000000010000000,
      S_ADD_Y  = 15'b000000100000000,
      S_MUL_LO = 15'b000001000000000,
      S_SUM    = 15'b000010000000000,
      S_RND_H  = 15'b000100000000000,
      S_ADD_H  = 15'b001000000000000,
      S_ROT_B  = 15'b010000000000000,
      S_OUT    = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [ddpi_pkg::IterW-1:0] iter_ff, iter_in;

   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic flip_ff, flip_in;

   logic signed [ddpi_pkg::LinSpeedW-1:0] v_ff, v_in;
   logic signed [ddpi_pkg::YawRateW-1:0]  w_ff, w_in;
   logic [ddpi_pkg::ElapsedW-1:0]         dt_ff, dt_in;
   logic signed [ddpi_pkg::QuatW-1:0]     sn_ff, sn_in, cs_ff, cs_in;

   logic signed [58:0] prod_ff, prod_in;
   logic [17:0]        pl_ff, pl_in;
   logic signed [60:0] acc_ff, acc_in;
   logic signed [32:0] rnd_ff, rnd_in;

   logic signed [ddpi_pkg::PosW-1:0] x_ff, x_in, y_ff, y_in;
   logic [ddpi_pkg::AngleW-1:0]      heading_ff, heading_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [ddpi_pkg::PosW-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic signed [ddpi_pkg::QuatW-1:0] rsp_qz_ff, rsp_qz_in, rsp_qw_ff, rsp_qw_in;

   logic               req_accept;
   logic               out_free;
   logic [31:0]        heading_sum;
   logic [31:0]        ang_src;
   logic               load_flip;
   logic signed [31:0] load_z;
   logic signed [31:0] shx, shy;
   logic [31:0]        atan_val;
   logic signed [15:0] trig_c_raw, trig_s_raw, trig_c, trig_s;
   logic signed [32:0] mul_a;
   logic signed [25:0] mul_b;
   logic signed [58:0] x_round_sum;
   logic signed [60:0] h_round_sum;
   logic signed [32:0] rnd_x;
   logic signed [31:0] sat_src, sat_res;
   logic signed [33:0] sat_sum;

   function automatic logic signed [15:0] to_q14(input logic signed [31:0] val);
      logic signed [32:0] biased;
      logic signed [16:0] scaled;
      logic signed [15:0] res;
      biased = $signed({val[31], val}) + 33'sd32768;
      scaled = $signed(biased[32:16]);
      if (scaled > 17'sd16384) begin
         res = 16'sd16384;
      end else if (scaled < -17'sd16384) begin
         res = -16'sd16384;
      end else begin
         res = scaled[15:0];
      end
      return res;
   endfunction

   assign req_accept = req_chan.valid && (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.pos_x  = rsp_x_ff;
   assign rsp_chan.pos_y  = rsp_y_ff;
   assign rsp_chan.quat_z = rsp_qz_ff;
   assign rsp_chan.quat_w = rsp_qw_ff;

   // angle load with fold into the right half plane
   assign heading_sum = heading_ff + rnd_ff[31:0];
   assign ang_src     = (state_ff == S_IDLE) ? {heading_ff[30:0], 1'b0} : heading_sum;
   assign load_flip   = ang_src[31] ^ ang_src[30];
   assign load_z      = $signed({ang_src[31] ^ load_flip, ang_src[30:0]});

   // rotator step
   assign shx      = cy_ff >>> iter_ff;
   assign shy      = cx_ff >>> iter_ff;
   assign atan_val = ddpi_pkg::atan_angle(iter_ff);

   assign trig_c_raw = to_q14(cx_ff);
   assign trig_s_raw = to_q14(cy_ff);
   assign trig_c     = flip_ff ? -trig_c_raw : trig_c_raw;
   assign trig_s     = flip_ff ? -trig_s_raw : trig_s_raw;

   // shared multiplier operands
   always_comb begin
      unique case (state_ff)
         S_MUL_VC: begin
            mul_a = $signed({{17{v_ff[15]}}, v_ff});
            mul_b = $signed({{10{cs_ff[15]}}, cs_ff});
         end
         S_RND_X: begin
            mul_a = $signed({{17{v_ff[15]}}, v_ff});
            mul_b = $signed({{10{sn_ff[15]}}, sn_ff});
         end
         S_MUL_XD, S_ADD_X: begin
            mul_a = prod_ff[32:0];
            mul_b = $signed({6'd0, dt_ff});
         end
         S_RND_Y: begin
            mul_a = $signed({{17{w_ff[15]}}, w_ff});
            mul_b = $signed({6'd0, dt_ff});
         end
         S_ADD_Y: begin
            mul_a = $signed({{15{prod_ff[35]}}, prod_ff[35:18]});
            mul_b = ddpi_pkg::RadToBam;
         end
         S_MUL_LO: begin
            mul_a = $signed({15'd0, pl_ff});
            mul_b = ddpi_pkg::RadToBam;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // shifts that round half away from zero
   assign x_round_sum = prod_ff + 59'sh2000_0000 - $signed({58'd0, prod_ff[58]});
   assign rnd_x       = $signed({{4{x_round_sum[58]}}, x_round_sum[58:30]});
   assign h_round_sum = acc_ff + 61'sh800_0000 - $signed({60'd0, acc_ff[60]});

   // saturating position update
   assign sat_src = (state_ff == S_ADD_X) ? x_ff : y_ff;
   assign sat_sum = $signed({{2{sat_src[31]}}, sat_src}) + $signed({rnd_ff[32], rnd_ff});
   always_comb begin
      if (sat_sum[33:31] == 3'b000 || sat_sum[33:31] == 3'b111) begin
         sat_res = sat_sum[31:0];
      end else if (sat_sum[33]) begin
         sat_res = $signed({1'b1, 31'd0});
      end else begin
         sat_res = $signed({1'b0, {31{1'b1}}});
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      flip_in      = flip_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      dt_in        = dt_ff;
      sn_in        = sn_ff;
      cs_in        = cs_ff;
      pl_in        = pl_ff;
      acc_in       = acc_ff;
      rnd_in       = rnd_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      heading_in   = heading_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_qz_in    = rsp_qz_ff;
      rsp_qw_in    = rsp_qw_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               v_in     = req_chan.lin_speed;
               w_in     = req_chan.yaw_rate;
               dt_in    = req_chan.elapsed;
               cx_in    = ddpi_pkg::CordicGain;
               cy_in    = '0;
               cz_in    = load_z;
               flip_in  = load_flip;
               iter_in  = '0;
               state_in = S_ROT_A;
            end
         end
         S_ROT_A, S_ROT_B: begin
            if (cz_ff[31]) begin
               cx_in = cx_ff + shx;
               cy_in = cy_ff - shy;
               cz_in = cz_ff + $signed(atan_val);
            end else begin
               cx_in = cx_ff - shx;
               cy_in = cy_ff + shy;
               cz_in = cz_ff - $signed(atan_val);
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ddpi_pkg::IterLast) begin
               state_in = (state_ff == S_ROT_A) ? S_FIN_A : S_OUT;
            end
         end
         S_FIN_A: begin
            cs_in    = trig_c;
            sn_in    = trig_s;
            state_in = S_MUL_VC;
         end
         S_MUL_VC: begin
            state_in = S_MUL_XD;
         end
         S_MUL_XD: begin
            state_in = S_RND_X;
         end
         S_RND_X: begin
            rnd_in   = rnd_x;
            state_in = S_ADD_X;
         end
         S_ADD_X: begin
            x_in     = sat_res;
            state_in = S_RND_Y;
         end
         S_RND_Y: begin
            rnd_in   = rnd_x;
            state_in = S_ADD_Y;
         end
         S_ADD_Y: begin
            y_in     = sat_res;
            pl_in    = prod_ff[17:0];
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            acc_in   = $signed({prod_ff[42:0], 18'd0});
            state_in = S_SUM;
         end
         S_SUM: begin
            acc_in   = acc_ff + $signed({{2{prod_ff[58]}}, prod_ff});
            state_in = S_RND_H;
         end
         S_RND_H: begin
            rnd_in   = h_round_sum[60:28];
            state_in = S_ADD_H;
         end
         S_ADD_H: begin
            heading_in = heading_sum;
            cx_in      = ddpi_pkg::CordicGain;
            cy_in      = '0;
            cz_in      = load_z;
            flip_in    = load_flip;
            iter_in    = '0;
            state_in   = S_ROT_B;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_ff;
               rsp_y_in     = y_ff;
               rsp_qz_in    = trig_s;
               rsp_qw_in    = trig_c;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         x_ff         <= '0;
         y_ff         <= '0;
         heading_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         heading_ff   <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      flip_ff   <= flip_in;
      v_ff      <= v_in;
      w_ff      <= w_in;
      dt_ff     <= dt_in;
      sn_ff     <= sn_in;
      cs_ff     <= cs_in;
      prod_ff   <= prod_in;
      pl_ff     <= pl_in;
      acc_ff    <= acc_in;
      rnd_ff    <= rnd_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_qz_ff <= rsp_qz_in;
      rsp_qw_ff <= rsp_qw_in;
   end

endmodule

`default_nettype wire
